FILE: hw/rtl/ihc_pkg.sv
// Shared constants, types and helpers for the identifier-to-colour pipeline.
`timescale 1ns / 1ps

package ihc_pkg;

	// fraction bits of the internal HSL arithmetic
	localparam int FRAC_BITS = 16;
	localparam int SHL_AMT   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SHR_AMT   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
	// p, q and q-p need one integer bit on top of the fraction
	localparam int PQ_W      = FRAC_BITS + 1;

	// pipeline depth, stage 1 is the input register, the last is the output register
	localparam int STAGES    = 9;

	// configuration registers
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = CFG_IDX_W'(1);
	localparam logic [15:0] SAT_RESET   = 16'd45875;
	localparam logic [15:0] LIGHT_RESET = 16'd32768;

	// golden-ratio hash multiplier, 2654435761
	localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;

	// modulo 45 by reciprocal: floor(v*1456/2^16) is v/45 or one short
	localparam logic [5:0]  MOD45    = 6'd45;
	localparam logic [10:0] RECIP45  = 11'd1456;

	typedef logic [8:0] deg_t;

	localparam deg_t DEG_60  = 9'd60;
	localparam deg_t DEG_120 = 9'd120;
	localparam deg_t DEG_180 = 9'd180;
	localparam deg_t DEG_240 = 9'd240;
	localparam deg_t DEG_360 = 9'd360;

	typedef logic [STAGES-1:0] stage_en_t;

	typedef struct packed {
		deg_t red;
		deg_t green;
		deg_t blue;
	} hue_t;

	typedef struct packed {
		logic            zero;
		logic [7:0]      gray;
		logic [PQ_W-1:0] p;
		logic [PQ_W-1:0] q;
		logic [PQ_W-1:0] diff;
	} coef_t;

	// Q0.16 register value to Q0.FRAC_BITS
	function automatic logic [FRAC_BITS-1:0] to_internal(input logic [15:0] v);
		logic [FRAC_BITS+15:0] w;
		w = {{FRAC_BITS{1'b0}}, v};
		w = (w << SHL_AMT) >> SHR_AMT;
		return w[FRAC_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/ihc_hash.sv
// Identifier hash and reduction to a hue in degrees, with the three channel offsets.
`timescale 1ns / 1ps

module ihc_hash import ihc_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [63:0] ident,
	output hue_t        hue
);

	// S1: partial products, upper half only needs its low 32 bits
	logic [63:0] lo_mul;
	logic [31:0] hi_mul;
	logic [63:0] lo_s1;
	logic [31:0] hi_s1;

	assign lo_mul = ident[31:0] * HASH_MUL;
	assign hi_mul = ident[63:32] * HASH_MUL;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s1 <= lo_mul;
			hi_s1 <= hi_mul;
		end
	end

	// S2: product modulo 2^64
	logic [63:0] prod_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2 <= lo_s1 + {hi_s1, 32'b0};
		end
	end

	// S3: x mod 360 = 8*((x>>3) mod 45) + x[2:0]; 2^12 = 1 mod 45, so sum 12-bit digits
	logic [60:0] y;
	logic [14:0] dsum;
	logic [12:0] fold1;
	logic [12:0] v13_s3;
	logic [2:0]  r3_s3;

	assign y     = prod_s2[63:3];
	assign dsum  = 15'(y[11:0]) + 15'(y[23:12]) + 15'(y[35:24]) + 15'(y[47:36])
		+ 15'(y[59:48]) + 15'(y[60]);
	assign fold1 = 13'(dsum[11:0]) + 13'(dsum[14:12]);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			v13_s3 <= fold1;
			r3_s3  <= prod_s2[2:0];
		end
	end

	// S4: last fold to 12 bits, reciprocal estimate of the quotient
	logic [12:0] fold2;
	logic [11:0] v12;
	logic [22:0] qmul;
	logic [11:0] v12_s4;
	logic [6:0]  q45_s4;
	logic [2:0]  r3_s4;

	assign fold2 = 13'(v13_s3[11:0]) + 13'(v13_s3[12]);
	assign v12   = fold2[11:0];
	assign qmul  = v12 * RECIP45;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			v12_s4 <= v12;
			q45_s4 <= qmul[22:16];
			r3_s4  <= r3_s3;
		end
	end

	// S5: remainder below 90, one correction step, then the hue
	logic [11:0] q45x;
	logic [11:0] rem;
	logic [5:0]  rfix;
	deg_t        deg_s5;

	assign q45x = q45_s4 * MOD45;
	assign rem  = v12_s4 - q45x;
	assign rfix = (rem[6:0] >= 7'(MOD45)) ? 6'(rem[6:0] - 7'(MOD45)) : rem[5:0];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			deg_s5 <= {rfix, r3_s4};
		end
	end

	// S6: channel hues, red +120 and blue -120 with wrap
	deg_t tr;
	deg_t tb;
	hue_t hue_s6;

	assign tr = (deg_s5 + DEG_120 >= DEG_360) ? deg_s5 + DEG_120 - DEG_360 : deg_s5 + DEG_120;
	assign tb = (deg_s5 >= DEG_120) ? deg_s5 - DEG_120 : deg_s5 + DEG_240;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			hue_s6.red   <= tr;
			hue_s6.green <= deg_s5;
			hue_s6.blue  <= tb;
		end
	end

	assign hue = hue_s6;

endmodule

FILE: hw/rtl/ihc_coef.sv
// HSL p and q terms from saturation and lightness, carried alongside the hash.
`timescale 1ns / 1ps

module ihc_coef import ihc_pkg::*; (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [15:0] saturation,
	input  logic [15:0] lightness,
	output coef_t       coef
);

	localparam int FB = FRAC_BITS;

	// S1: l*s
	logic [FB-1:0]   s_in;
	logic [FB-1:0]   l_in;
	logic [2*FB-1:0] ls_full;
	logic [FB-1:0]   s_s1;
	logic [FB-1:0]   l_s1;
	logic [FB-1:0]   ls_s1;

	assign s_in    = to_internal(saturation);
	assign l_in    = to_internal(lightness);
	assign ls_full = l_in * s_in;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			s_s1  <= s_in;
			l_s1  <= l_in;
			ls_s1 <= ls_full[2*FB-1:FB];
		end
	end

	// S2: q, p, gray level
	logic [FB+1:0] q_lo;
	logic [FB+1:0] q_hi;
	logic [FB+1:0] qn;
	logic [FB+1:0] l2;
	logic [FB+1:0] pn;
	logic [FB+7:0] g255;
	coef_t         coef_s2;

	assign q_lo = (FB+2)'(l_s1) + (FB+2)'(ls_s1);
	assign q_hi = (FB+2)'(l_s1) + (FB+2)'(s_s1) - (FB+2)'(ls_s1);
	// l below one half when its top fraction bit is clear
	assign qn   = l_s1[FB-1] ? q_hi : q_lo;
	assign l2   = (FB+2)'({l_s1, 1'b0});
	assign pn   = (l2 >= qn) ? l2 - qn : '0;
	assign g255 = ((FB+8)'(l_s1) << 8) - (FB+8)'(l_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			coef_s2.zero <= (s_s1 == '0);
			coef_s2.gray <= g255[FB+7:FB];
			coef_s2.q    <= qn[PQ_W-1:0];
			coef_s2.p    <= pn[PQ_W-1:0];
			coef_s2.diff <= '0;
		end
	end

	// S3: q - p
	coef_t coef_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			coef_s3.zero <= coef_s2.zero;
			coef_s3.gray <= coef_s2.gray;
			coef_s3.p    <= coef_s2.p;
			coef_s3.q    <= coef_s2.q;
			coef_s3.diff <= (coef_s2.q >= coef_s2.p) ? coef_s2.q - coef_s2.p : '0;
		end
	end

	// S4..S6: keep step with the hue reduction
	coef_t coef_s4;
	coef_t coef_s5;
	coef_t coef_s6;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			coef_s4 <= coef_s3;
		end
		if (en[4]) begin
			coef_s5 <= coef_s4;
		end
		if (en[5]) begin
			coef_s6 <= coef_s5;
		end
	end

	assign coef = coef_s6;

endmodule

FILE: hw/rtl/ihc_channel.sv
// One colour channel: piecewise hue rule, scale to 0..255, gray override.
`timescale 1ns / 1ps

module ihc_channel import ihc_pkg::*; (
	input  logic       clk,
	input  stage_en_t  en,
	input  deg_t       hue,
	input  coef_t      coef,
	output logic [7:0] chan
);

	// S7: ramp product and base term times 60
	logic [7:0]      m;
	logic [PQ_W-1:0] base;
	logic [PQ_W+7:0] mul;
	logic [PQ_W+5:0] base60;
	logic [PQ_W+7:0] mul_s7;
	logic [PQ_W+5:0] base60_s7;
	logic            zero_s7;
	logic [7:0]      gray_s7;

	always_comb begin
		if (hue < DEG_60) begin
			m    = hue[7:0];
			base = coef.p;
		end else if (hue < DEG_180) begin
			m    = '0;
			base = coef.q;
		end else if (hue < DEG_240) begin
			m    = 8'(DEG_240 - hue);
			base = coef.p;
		end else begin
			m    = '0;
			base = coef.p;
		end
	end

	assign mul    = coef.diff * m;
	assign base60 = ((PQ_W+6)'(base) << 6) - ((PQ_W+6)'(base) << 2);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			mul_s7    <= mul;
			base60_s7 <= base60;
			zero_s7   <= coef.zero;
			gray_s7   <= coef.gray;
		end
	end

	// S8: value scaled by 60
	logic [PQ_W+8:0] scaled_s8;
	logic            zero_s8;
	logic [7:0]      gray_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			scaled_s8 <= (PQ_W+9)'(base60_s7) + (PQ_W+9)'(mul_s7);
			zero_s8   <= zero_s7;
			gray_s8   <= gray_s7;
		end
	end

	// S9: *255/(60<<FRAC_BITS) is exactly *17>>(FRAC_BITS+2), then cap
	localparam int X_W = PQ_W + 14;
	localparam int C_W = X_W - FRAC_BITS - 2;

	logic [X_W-1:0] x17;
	logic [C_W-1:0] cfull;
	logic [7:0]     capped;
	logic [7:0]     chan_s9;

	assign x17    = (X_W'(scaled_s8) << 4) + X_W'(scaled_s8);
	assign cfull  = x17[X_W-1:FRAC_BITS+2];
	assign capped = (|cfull[C_W-1:8]) ? 8'hFF : cfull[7:0];

	always_ff @(posedge clk) begin
		if (en[8]) begin
			chan_s9 <= zero_s8 ? gray_s8 : capped;
		end
	end

	assign chan = chan_s9;

endmodule

FILE: hw/rtl/id_hash_to_hsl_color.sv
// Top level: identifier to RGB colour through a hashed hue and HSL conversion.
`timescale 1ns / 1ps

// Each 64-bit identifier is hashed (times 2654435761 modulo 2^64), reduced
// modulo 360 to a hue, and converted together with the saturation and
// lightness registers from HSL to 8-bit red, green and blue. The block is a
// nine-stage pipeline, from the input register to the result register: one
// transaction per clock in and out while rgb_stall is low. Stage depth is set
// by the 32x32 hash partial products in the first stage and the channel ramp
// multiply in the seventh. Stall runs back stage by stage, so empty stages
// fill while the output waits and new identifiers are still taken. Register 0 is
// saturation (Q0.16, reset 45875), register 1 lightness (Q0.16, reset 32768);
// other indexes are ignored. cfg_ready is always high. Write the registers
// only while the pipeline is empty; a transaction takes the values present
// when it is accepted. Zero saturation gives gray on all three channels.
module id_hash_to_hsl_color import ihc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// identifier channel
	input  logic                 ident_valid,
	output logic                 ident_stall,
	input  logic [63:0]          ident,
	// colour channel
	output logic                 rgb_valid,
	input  logic                 rgb_stall,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// Register file
	logic [15:0] sat_q;
	logic [15:0] light_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q   <= SAT_RESET;
			light_q <= LIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SATURATION: sat_q   <= cfg_data;
				REG_LIGHTNESS:  light_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control: a stage loads when it is empty or the next one loads
	logic [STAGES-1:0] vld_q;
	stage_en_t         en;

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || !rgb_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= ident_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ident_stall = !en[0];
	assign rgb_valid   = vld_q[STAGES-1];

	// Hue path, stages 1 to 6
	hue_t hue;

	ihc_hash u_hash (
		.clk   (clk),
		.en    (en),
		.ident (ident),
		.hue   (hue)
	);

	// p/q terms, stages 1 to 6, in step with the hue
	coef_t coef;

	ihc_coef u_coef (
		.clk        (clk),
		.en         (en),
		.saturation (sat_q),
		.lightness  (light_q),
		.coef       (coef)
	);

	// Channels, stages 7 to 9; stage 9 is the output register
	ihc_channel u_red (
		.clk  (clk),
		.en   (en),
		.hue  (hue.red),
		.coef (coef),
		.chan (red)
	);

	ihc_channel u_green (
		.clk  (clk),
		.en   (en),
		.hue  (hue.green),
		.coef (coef),
		.chan (green)
	);

	ihc_channel u_blue (
		.clk  (clk),
		.en   (en),
		.hue  (hue.blue),
		.coef (coef),
		.chan (blue)
	);

endmodule

FILE: verif/id_hash_to_hsl_color_tb.sv
// Self-checking testbench for the identifier-to-colour pipeline.
`timescale 1ns / 1ps

// Test plan
//  - A directed table comes first. It covers the identifier extremes, the hue
//    breakpoints and the wrap points of the red and blue hues, zero saturation
//    (gray), full saturation, and lightness just below and at one half. Rows
//    whose colour is easy to work out by hand carry it typed in. The other
//    rows are checked against the predictor below.
//  - Random identifiers follow in eight register phases, with the extremes
//    among them. Each phase also writes one unused register index, and the
//    block must ignore that write.
//  - Both channels idle for a random spell on each transaction. There
//    are stretches with no idling. Twice the colour side holds off for a long
//    stretch so that the pipeline fills and stalls the identifier side.
//  - Registers are written only with the pipeline empty. Every transaction
//    gives exactly one colour, so an empty queue of expected colours means an
//    idle block.
module id_hash_to_hsl_color_tb import ihc_pkg::*;;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RAND_ITEMS   = 1300;
	localparam int RAND_PHASES  = 8;
	localparam int HOLD_CYCLES  = 120;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// one directed transaction: register values in force, identifier given
	// directly or as a wanted hue, and an optional hand-worked colour
	typedef struct packed {
		logic [15:0] sat;
		logic [15:0] light;
		logic        by_hue;
		logic [63:0] val;
		logic        typed;
		rgb_t        colour;
	} dir_row_t;

	localparam dir_row_t DIRECTED[20] = '{
		// reset registers, hue 0: red sits at the q plateau, green and blue on p
		'{SAT_RESET, LIGHT_RESET, 1'b0, 64'd0, 1'b1, '{8'd216, 8'd38, 8'd38}},
		'{SAT_RESET, LIGHT_RESET, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b0, 64'd1, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b0, 64'h8000_0000_0000_0000, 1'b0, '0},
		// either side of each breakpoint, and the red and blue wrap points
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd59, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd60, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd119, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd120, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd179, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd180, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd239, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd240, 1'b0, '0},
		'{SAT_RESET, LIGHT_RESET, 1'b1, 64'd359, 1'b0, '0},
		// zero saturation: gray of (l*255) >> 16 on every channel
		'{16'd0, 16'd0, 1'b1, 64'd100, 1'b1, '{8'd0, 8'd0, 8'd0}},
		'{16'd0, 16'hFFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{8'd254, 8'd254, 8'd254}},
		'{16'd0, 16'h8000, 1'b1, 64'd300, 1'b1, '{8'd127, 8'd127, 8'd127}},
		// black at zero lightness; at full lightness red is 255, green and blue 254
		'{16'hFFFF, 16'd0, 1'b1, 64'd30, 1'b1, '{8'd0, 8'd0, 8'd0}},
		'{16'hFFFF, 16'hFFFF, 1'b0, 64'd0, 1'b1, '{8'd255, 8'd254, 8'd254}},
		// lightness just under one half takes the l + l*s branch
		'{16'hFFFF, 16'h7FFF, 1'b1, 64'd210, 1'b0, '0},
		'{16'd1, 16'h8000, 1'b1, 64'd200, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 ident_valid = 1'b0;
	logic                 ident_stall;
	logic [63:0]          ident = '0;
	logic                 rgb_valid;
	logic                 rgb_stall = 1'b0;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SATURATION;
	logic [15:0]          cfg_data = '0;

	// register copies for the predictor, updated when a write is accepted
	logic [15:0] cur_sat = SAT_RESET;
	logic [15:0] cur_light = LIGHT_RESET;

	// colours still owed by the block, oldest first
	rgb_t pending_colours[$];

	int          errors = 0;
	int unsigned cycles = 0;
	bit          sender_rush = 1'b0;

	id_hash_to_hsl_color dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.ident_valid (ident_valid),
		.ident_stall (ident_stall),
		.ident       (ident),
		.rgb_valid   (rgb_valid),
		.rgb_stall   (rgb_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// hue of an identifier: golden-ratio hash modulo 2^64, then modulo 360
	function automatic int hue_of(input logic [63:0] id);
		logic [63:0] hashed;
		hashed = id * 64'(HASH_MUL);
		return int'(hashed % 64'd360);
	endfunction

	// one channel from its hue; the ramp is kept scaled by 60 to stay integral
	function automatic logic [7:0] ramp_level(input longint unsigned p, input longint unsigned q,
			input int t);
		longint unsigned span, lvl, c;
		span = (q >= p) ? q - p : 0;
		if (t < int'(DEG_60)) begin
			lvl = 60 * p + span * longint'(t);
		end else if (t < int'(DEG_180)) begin
			lvl = 60 * q;
		end else if (t < int'(DEG_240)) begin
			lvl = 60 * p + span * longint'(int'(DEG_240) - t);
		end else begin
			lvl = 60 * p;
		end
		c = (lvl * 255) / (64'd60 << FRAC_BITS);
		return (c > 255) ? 8'd255 : 8'(c);
	endfunction

	// colour the block must give for an identifier under the current registers
	function automatic rgb_t hsl_colour_of(input logic [63:0] id);
		int              hue, hue_r, hue_b;
		longint unsigned s, l, ls, q, p, g;
		rgb_t            res;
		hue = hue_of(id);
		s = (64'(cur_sat) << SHL_AMT) >> SHR_AMT;
		l = (64'(cur_light) << SHL_AMT) >> SHR_AMT;
		if (s == 0) begin
			g = (l * 255) >> FRAC_BITS;
			if (g > 255)
				g = 255;
			res = '{8'(g), 8'(g), 8'(g)};
			return res;
		end
		ls = (l * s) >> FRAC_BITS;
		q = (l < (64'd1 << (FRAC_BITS - 1))) ? l + ls : l + s - ls;
		p = (2 * l >= q) ? 2 * l - q : 0;
		// red leads by 120 degrees, blue lags by 120, both wrapped into 0..359
		hue_r = hue + int'(DEG_120);
		if (hue_r >= int'(DEG_360))
			hue_r -= int'(DEG_360);
		hue_b = hue - int'(DEG_120);
		if (hue_b < 0)
			hue_b += int'(DEG_360);
		res.red = ramp_level(p, q, hue_r);
		res.green = ramp_level(p, q, hue);
		res.blue = ramp_level(p, q, hue_b);
		return res;
	endfunction

	// random identifier that hashes to the wanted hue; the hash multiplier is
	// odd and coprime to 360 in its residue, so a short walk always gets there
	function automatic logic [63:0] ident_for_hue(input int target);
		logic [63:0] id;
		id = {$urandom, $urandom};
		while (hue_of(id) != target)
			id++;
		return id;
	endfunction

	// offer one identifier after a random gap; valid stays up afterwards so
	// that back-to-back transactions never lower and raise it in one step
	task automatic offer_ident(input logic [63:0] id, input rgb_t want);
		int gap;
		gap = sender_rush ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			ident_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ident_valid <= 1'b1;
		ident <= id;
		@(posedge clk);
		while (ident_stall)
			@(posedge clk);
		pending_colours.push_back(want);
	endtask

	// stop offering and wait for every owed colour; one colour per transaction,
	// so an empty queue means the pipeline is empty
	task automatic drain_pipeline();
		ident_valid <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// saturation, lightness and one write to an unused index, valid held high
	// across the burst
	task automatic program_hsl(input logic [15:0] sat, input logic [15:0] light);
		logic [CFG_IDX_W-1:0] idx[3];
		logic [15:0]          val[3];
		idx[0] = REG_SATURATION;
		idx[1] = REG_LIGHTNESS;
		idx[2] = ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
		val[0] = sat;
		val[1] = light;
		val[2] = 16'($urandom);
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx[k] == REG_SATURATION)
				cur_sat = val[k];
			else if (idx[k] == REG_LIGHTNESS)
				cur_light = val[k];
		end
		cfg_valid <= 1'b0;
	endtask

	// colour side: random stall per transaction, bursts with no stall, and two
	// long hold-offs that back the pipeline up into the identifier side
	initial begin : colour_sink
		int   stall_n;
		int   taken;
		bit   rush;
		rgb_t want;
		taken = 0;
		rush = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rush = ~rush;
			stall_n = rush ? 0 : $urandom_range(0, 7);
			if (taken == 400 || taken == 1000)
				stall_n = HOLD_CYCLES;
			if (stall_n > 0) begin
				rgb_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			rgb_stall <= 1'b0;
			@(posedge clk);
			while (!rgb_valid)
				@(posedge clk);
			taken++;
			if (pending_colours.size() == 0) begin
				$display("%0t: colour with none owed: expected nothing, got %0d %0d %0d",
					$time, red, green, blue);
				errors++;
			end else begin
				want = pending_colours.pop_front();
				if (red !== want.red) begin
					$display("%0t: red mismatch: expected %0d, got %0d", $time, want.red, red);
					errors++;
				end
				if (green !== want.green) begin
					$display("%0t: green mismatch: expected %0d, got %0d",
						$time, want.green, green);
					errors++;
				end
				if (blue !== want.blue) begin
					$display("%0t: blue mismatch: expected %0d, got %0d", $time, want.blue, blue);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [63:0] id;
		logic [15:0] sat, light;
		dir_row_t    row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; registers change only with the pipeline empty
		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.sat != cur_sat || row.light != cur_light) begin
				drain_pipeline();
				program_hsl(row.sat, row.light);
			end
			id = row.by_hue ? ident_for_hue(int'(row.val)) : row.val;
			offer_ident(id, row.typed ? row.colour : hsl_colour_of(id));
		end

		// random identifiers under a range of register settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					sat = SAT_RESET;
					light = LIGHT_RESET;
				end
				1: begin
					sat = 16'd0;
					light = 16'($urandom);
				end
				2: begin
					sat = 16'hFFFF;
					light = 16'hFFFF;
				end
				3: begin
					sat = 16'hFFFF;
					light = 16'd0;
				end
				4: begin
					sat = 16'($urandom);
					light = 16'h7FFF;
				end
				5: begin
					sat = 16'($urandom);
					light = 16'h8000;
				end
				default: begin
					sat = 16'($urandom);
					light = 16'($urandom);
				end
			endcase
			drain_pipeline();
			program_hsl(sat, light);
			for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
				if ($urandom_range(0, 47) == 0)
					sender_rush = ~sender_rush;
				case ($urandom_range(0, 19))
					0: id = '0;
					1: id = '1;
					2: id = 64'd1 << $urandom_range(0, 63);
					default: id = {$urandom, $urandom};
				endcase
				offer_ident(id, hsl_colour_of(id));
			end
		end

		// all offered; wait for the tail of the pipeline, then a little extra
		// in case anything unowed follows
		ident_valid <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		repeat (2 * STAGES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
